// ===== sv/hill_pkg.sv =====
// shared types, constants and modulo-26 helpers for the hill cipher block
package hill_pkg;

   localparam int LETTERS    = 26;
   localparam int GROUP_SIZE = 3;
   localparam int KEY_WIDTH  = 45;
   localparam int DATA_WIDTH = 64;
   localparam int ADDR_WIDTH = 4;

   typedef logic [4:0]       letter_type;
   typedef logic [8:0][4:0]  matrix_type;
   typedef logic [2:0][4:0]  vector_type;

   localparam letter_type PAD_LETTER = 5'd23;
   localparam matrix_type KEY_RESET  = 45'd1099512676353;

   // register select, taken from address bit 3
   localparam logic REG_KEY       = 1'b0;
   localparam logic REG_DIRECTION = 1'b1;

   typedef enum logic [2:0] {
      KEY_IDLE,
      KEY_REDUCE,
      KEY_ADJ,
      KEY_DET,
      KEY_INV
   } key_state_type;

   typedef struct packed {
      logic       busy;
      logic       decrypt;
      logic       invertible;
      matrix_type key_red;
      matrix_type inverse;
   } key_status_type;

   typedef struct packed {
      logic       valid;
      vector_type vec;
   } group_type;

   // x mod 26 for x below 4096: reciprocal estimate, then one correction
   function automatic letter_type mod26(input logic [11:0] x);
      logic [20:0] prod;
      logic [7:0]  q;
      logic [11:0] qm;
      logic [11:0] diff;
      logic [5:0]  rem;
      prod = 21'(x) * 21'd315;
      q    = prod[20:13];
      qm   = 12'({4'd0, q} * 12'd26);
      diff = x - qm;
      rem  = diff[5:0];
      return (rem >= 6'(LETTERS)) ? 5'(rem - 6'(LETTERS)) : rem[4:0];
   endfunction

   // single reduction of a 5-bit value
   function automatic letter_type red26(input letter_type x);
      return (x >= 5'(LETTERS)) ? 5'(x - 5'(LETTERS)) : x;
   endfunction

   function automatic letter_type mul_mod(input letter_type a, input letter_type b);
      logic [9:0] p;
      p = 10'(a) * 10'(b);
      return mod26({2'b00, p});
   endfunction

   // (a - b) mod 26 for a, b in 0..25
   function automatic letter_type sub_mod(input letter_type a, input letter_type b);
      logic [5:0] s;
      s = (a >= b) ? 6'(a) - 6'(b) : 6'(a) + 6'(LETTERS) - 6'(b);
      return s[4:0];
   endfunction

   // inverse of a unit mod 26, zero where none exists
   function automatic letter_type inv_lookup(input letter_type d);
      letter_type r;
      case (d)
         5'd1:    r = 5'd1;
         5'd3:    r = 5'd9;
         5'd5:    r = 5'd21;
         5'd7:    r = 5'd15;
         5'd9:    r = 5'd3;
         5'd11:   r = 5'd19;
         5'd15:   r = 5'd7;
         5'd17:   r = 5'd23;
         5'd19:   r = 5'd11;
         5'd21:   r = 5'd5;
         5'd23:   r = 5'd17;
         5'd25:   r = 5'd25;
         default: r = 5'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/hill_if.sv =====
// valid/ready channel interfaces for letters in and letters out
interface hill_req_if;
   logic                 valid;
   logic                 ready;
   hill_pkg::letter_type letter;
   logic                 end_of_message;

   modport source (output valid, output letter, output end_of_message, input ready);
   modport sink   (input valid, input letter, input end_of_message, output ready);
endinterface

interface hill_rsp_if;
   logic                 valid;
   logic                 ready;
   hill_pkg::letter_type out_letter;
   logic                 group_last;
   logic                 key_singular;

   modport source (output valid, output out_letter, output group_last,
                   output key_singular, input ready);
   modport sink   (input valid, input out_letter, input group_last,
                   input key_singular, output ready);
endinterface

// ===== sv/hill_key_unit.sv =====
// register port, key storage and multi-cycle inverse-key sequencer
module hill_key_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hill_pkg::ADDR_WIDTH-1:0]     paddr,
   input  logic [hill_pkg::DATA_WIDTH-1:0]     pwdata,
   output logic [hill_pkg::DATA_WIDTH-1:0]     prdata,
   output logic                                pready,
   output hill_pkg::key_status_type            key_status
);

   hill_pkg::key_state_type state_ff, state_in;
   hill_pkg::matrix_type    key_ff;
   hill_pkg::matrix_type    kred_ff, kred_in;
   hill_pkg::matrix_type    adj_ff, adj_in;
   hill_pkg::matrix_type    inverse_ff, inverse_in;
   hill_pkg::letter_type    det_ff, det_in;
   hill_pkg::letter_type    dinv;
   logic                    invertible_ff;
   logic                    direction_ff;
   logic                    wr;
   logic                    key_wr;
   logic [11:0]             det_sum;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;
   assign key_wr = wr && (paddr[3] == hill_pkg::REG_KEY);

   always_comb begin
      if (paddr[3] == hill_pkg::REG_DIRECTION) begin
         prdata = {{(hill_pkg::DATA_WIDTH-1){1'b0}}, direction_ff};
      end else begin
         prdata = {{(hill_pkg::DATA_WIDTH-hill_pkg::KEY_WIDTH){1'b0}}, key_ff};
      end
   end

   // sequencer: a key write (re)starts the walk through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hill_pkg::KEY_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hill_pkg::KEY_IDLE:   state_in = hill_pkg::KEY_IDLE;
         hill_pkg::KEY_REDUCE: state_in = hill_pkg::KEY_ADJ;
         hill_pkg::KEY_ADJ:    state_in = hill_pkg::KEY_DET;
         hill_pkg::KEY_DET:    state_in = hill_pkg::KEY_INV;
         hill_pkg::KEY_INV:    state_in = hill_pkg::KEY_IDLE;
         default:              state_in = hill_pkg::KEY_IDLE;
      endcase
      if (key_wr) begin
         state_in = hill_pkg::KEY_REDUCE;
      end
   end

   // per-stage arithmetic
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         kred_in[i] = hill_pkg::red26(key_ff[i]);
      end

      adj_in[0] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[4], kred_ff[8]),
                                    hill_pkg::mul_mod(kred_ff[5], kred_ff[7]));
      adj_in[1] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[2], kred_ff[7]),
                                    hill_pkg::mul_mod(kred_ff[1], kred_ff[8]));
      adj_in[2] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[1], kred_ff[5]),
                                    hill_pkg::mul_mod(kred_ff[2], kred_ff[4]));
      adj_in[3] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[5], kred_ff[6]),
                                    hill_pkg::mul_mod(kred_ff[3], kred_ff[8]));
      adj_in[4] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[0], kred_ff[8]),
                                    hill_pkg::mul_mod(kred_ff[2], kred_ff[6]));
      adj_in[5] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[2], kred_ff[3]),
                                    hill_pkg::mul_mod(kred_ff[0], kred_ff[5]));
      adj_in[6] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[3], kred_ff[7]),
                                    hill_pkg::mul_mod(kred_ff[4], kred_ff[6]));
      adj_in[7] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[1], kred_ff[6]),
                                    hill_pkg::mul_mod(kred_ff[0], kred_ff[7]));
      adj_in[8] = hill_pkg::sub_mod(hill_pkg::mul_mod(kred_ff[0], kred_ff[4]),
                                    hill_pkg::mul_mod(kred_ff[1], kred_ff[3]));

      // first-row expansion of the determinant
      det_sum = 12'(kred_ff[0]) * 12'(adj_ff[0])
              + 12'(kred_ff[1]) * 12'(adj_ff[3])
              + 12'(kred_ff[2]) * 12'(adj_ff[6]);
      det_in  = hill_pkg::mod26(det_sum);

      dinv = hill_pkg::inv_lookup(det_ff);
      for (int i = 0; i < 9; i++) begin
         inverse_in[i] = (dinv == 5'd0) ? 5'd0 : hill_pkg::mul_mod(adj_ff[i], dinv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= hill_pkg::KEY_RESET;
         direction_ff  <= 1'b0;
         kred_ff       <= hill_pkg::KEY_RESET;
         inverse_ff    <= hill_pkg::KEY_RESET;
         invertible_ff <= 1'b1;
      end else begin
         if (key_wr) begin
            key_ff <= pwdata[hill_pkg::KEY_WIDTH-1:0];
         end
         if (wr && (paddr[3] == hill_pkg::REG_DIRECTION)) begin
            direction_ff <= pwdata[0];
         end
         if (state_ff == hill_pkg::KEY_REDUCE) begin
            kred_ff <= kred_in;
         end
         if (state_ff == hill_pkg::KEY_INV) begin
            inverse_ff    <= inverse_in;
            invertible_ff <= (dinv != 5'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == hill_pkg::KEY_ADJ) begin
         adj_ff <= adj_in;
      end
      if (state_ff == hill_pkg::KEY_DET) begin
         det_ff <= det_in;
      end
   end

   assign key_status.busy       = (state_ff != hill_pkg::KEY_IDLE);
   assign key_status.decrypt    = direction_ff;
   assign key_status.invertible = invertible_ff;
   assign key_status.key_red    = kred_ff;
   assign key_status.inverse    = inverse_ff;

endmodule

// ===== sv/hill_collect.sv =====
// gathers letters into groups of three, pads short final groups
module hill_collect (
   input  logic                    clock,
   input  logic                    reset,
   hill_req_if.sink                req_ch,
   input  logic                    key_busy,
   input  logic                    grp_ready,
   output hill_pkg::group_type     grp
);

   logic [1:0]                  count_ff, count_in;
   hill_pkg::letter_type [1:0]  buf_ff;
   logic                        grp_valid_ff, grp_valid_in;
   hill_pkg::vector_type        vec_ff, vec_in;
   logic                        accept;
   logic                        completes;

   assign req_ch.ready = !key_busy && (!grp_valid_ff || grp_ready);
   assign accept       = req_ch.valid && req_ch.ready;
   assign completes    = (count_ff == 2'd2) || req_ch.end_of_message;

   always_comb begin
      vec_in = vec_ff;
      case (count_ff)
         2'd0:    vec_in = {hill_pkg::PAD_LETTER, hill_pkg::PAD_LETTER, req_ch.letter};
         2'd1:    vec_in = {hill_pkg::PAD_LETTER, req_ch.letter, buf_ff[0]};
         default: vec_in = {req_ch.letter, buf_ff[1], buf_ff[0]};
      endcase

      count_in     = count_ff;
      grp_valid_in = grp_valid_ff && !grp_ready;
      if (accept) begin
         if (completes) begin
            count_in     = 2'd0;
            grp_valid_in = 1'b1;
         end else begin
            count_in = count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= 2'd0;
         grp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         grp_valid_ff <= grp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !completes) begin
         buf_ff[count_ff[0]] <= req_ch.letter;
      end
      if (accept && completes) begin
         vec_ff <= vec_in;
      end
   end

   assign grp.valid = grp_valid_ff;
   assign grp.vec   = vec_ff;

endmodule

// ===== sv/hill_mix.sv =====
// matrix-vector product mod 26 and the three-letter result buffer
module hill_mix (
   input  logic                       clock,
   input  logic                       reset,
   input  hill_pkg::group_type        grp,
   input  hill_pkg::key_status_type   key_status,
   output logic                       grp_ready,
   hill_rsp_if.source                 rsp_ch
);

   hill_pkg::matrix_type        m;
   logic                        err;
   logic [11:0]                 row_sum [3];
   hill_pkg::vector_type        res_in;
   hill_pkg::vector_type        out_ff, out_in;
   logic                        err_ff;
   logic [1:0]                  left_ff, left_in;
   logic                        load;
   logic                        drain;

   always_comb begin
      m   = key_status.decrypt ? key_status.inverse : key_status.key_red;
      err = key_status.decrypt && !key_status.invertible;
      for (int r = 0; r < hill_pkg::GROUP_SIZE; r++) begin
         row_sum[r] = 12'(m[3*r])   * 12'(grp.vec[0])
                    + 12'(m[3*r+1]) * 12'(grp.vec[1])
                    + 12'(m[3*r+2]) * 12'(grp.vec[2]);
         res_in[r]  = err ? 5'd0 : hill_pkg::mod26(row_sum[r]);
      end
   end

   assign drain     = rsp_ch.valid && rsp_ch.ready;
   assign grp_ready = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_ch.ready);
   assign load      = grp.valid && grp_ready;

   always_comb begin
      left_in = left_ff;
      out_in  = out_ff;
      if (load) begin
         left_in = 2'd3;
         out_in  = res_in;
      end else if (drain) begin
         left_in = left_ff - 2'd1;
         out_in  = {5'd0, out_ff[2], out_ff[1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (load) begin
         err_ff <= err;
      end
   end

   assign rsp_ch.valid        = (left_ff != 2'd0);
   assign rsp_ch.out_letter   = out_ff[0];
   assign rsp_ch.group_last   = (left_ff == 2'd1);
   assign rsp_ch.key_singular = err_ff;

endmodule

// ===== sv/hill_cipher_3x3_mod26.sv =====
// top level of the streaming 3x3 hill cipher, modulo 26
//
// req_ch carries one letter (0..25) per transaction, end_of_message on the
// last letter of a message. letters are grouped in threes; a short final
// group is padded with 'x' (23). each group gives three rsp_ch transactions,
// group_last set on the third. decrypt mode uses the inverse key; a key with
// no inverse mod 26 gives letters of zero with key_singular set in decrypt mode.
// the letter that completes a group is registered in the group register, and
// its result passes through the result buffer before rsp_ch offers it.
// throughput: one letter per cycle sustained for full groups while rsp_ch.ready
// is high and the key unit idle; a padded group's three results hold off input.
// registers on the apb port: key_matrix at 0x0, direction at 0x8, 64-bit data.
// a key_matrix write starts the inverse computation (reduce, adjugate,
// determinant, inverse) in the key unit; req_ch.ready is low meanwhile.
// reset loads the identity key, encrypt mode and an empty group.
// when the receiver stalls, the result buffer holds; one finished group may
// wait in the group register, after which req_ch.ready drops.
module hill_cipher_3x3_mod26 (
   input  logic                              clock,
   input  logic                              reset,
   hill_req_if.sink                          req_ch,
   hill_rsp_if.source                        rsp_ch,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [hill_pkg::ADDR_WIDTH-1:0]   paddr,
   input  logic [hill_pkg::DATA_WIDTH-1:0]   pwdata,
   output logic [hill_pkg::DATA_WIDTH-1:0]   prdata,
   output logic                              pready
);

   hill_pkg::key_status_type key_status;
   hill_pkg::group_type      grp;
   logic                     grp_ready;

   // key storage, direction and the inverse-key sequencer
   hill_key_unit u_key (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .key_status (key_status)
   );

   // input register side: group assembly and padding
   hill_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .key_busy  (key_status.busy),
      .grp_ready (grp_ready),
      .grp       (grp)
   );

   // product mod 26 into the result buffer, drained one letter a transaction
   hill_mix u_mix (
      .clock      (clock),
      .reset      (reset),
      .grp        (grp),
      .key_status (key_status),
      .grp_ready  (grp_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== sv/hill_check.sv =====
// port-level checker for the hill cipher top level, with its bind
module hill_check (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  hill_pkg::letter_type              rsp_out_letter,
   input  logic                              rsp_group_last,
   input  logic                              rsp_key_singular,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [hill_pkg::ADDR_WIDTH-1:0]   paddr
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_letter) && $stable(rsp_group_last)
                                  && $stable(rsp_key_singular))
      else $error("result changed while stalled");

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_singular |-> rsp_out_letter == 5'd0)
      else $error("singular key result not zero");

   a_letter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_letter < 5'(hill_pkg::LETTERS))
      else $error("result letter out of range");

   a_key_busy: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[3] == hill_pkg::REG_KEY)
      |=> !req_ready)
      else $error("input taken during inverse computation");

endmodule

bind hill_cipher_3x3_mod26 hill_check u_hill_check (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_out_letter   (rsp_ch.out_letter),
   .rsp_group_last   (rsp_ch.group_last),
   .rsp_key_singular (rsp_ch.key_singular),
   .psel             (psel),
   .penable          (penable),
   .pwrite           (pwrite),
   .pready           (pready),
   .paddr            (paddr)
);
